/* rtl/cartridge_bank_controller_defines.svh */
// ----------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Shared assertion shorthands; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Word types, result codes, controller kinds and reset values.
// ----------------------------------------------------------------------------
package cbc_pkg;

	// Result codes.
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_OPEN = 3'd1;
	localparam logic [2:0] TGT_ROM  = 3'd2;
	localparam logic [2:0] TGT_RAM  = 3'd3;
	localparam logic [2:0] TGT_NIB  = 3'd4;
	localparam logic [2:0] TGT_CLK  = 3'd5;
	localparam logic [2:0] TGT_CTRL = 3'd6;

	// Controller kinds.
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_MBC1 = 3'd1;
	localparam logic [2:0] KIND_MBC2 = 3'd2;
	localparam logic [2:0] KIND_MBC3 = 3'd3;
	localparam logic [2:0] KIND_MBC5 = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_KIND      = 2'd0;
	localparam logic [1:0] REG_ROM_SIZE  = 2'd1;
	localparam logic [1:0] REG_RAM_COUNT = 2'd2;

	localparam logic [3:0] ROM_CODE_MAX = 4'd8;
	localparam int unsigned CLOCK_REGS = 5;
	localparam logic [3:0] ENABLE_KEY = 4'hA;

	// Clock byte reset values.
	localparam logic [7:0] CLOCK_RESET [CLOCK_REGS] = '{8'd0, 8'd0, 8'd12, 8'd1, 8'd0};

	typedef struct packed {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  write_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [22:0] mem_address;
		logic [7:0]  data;
	} rsp_t;

endpackage

/* rtl/cbc_if.sv */
// ----------------------------------------------------------------------------
// Cartridge bank controller channel interfaces
// Valid/ready channels for bus access words and result words.
// ----------------------------------------------------------------------------
interface cbc_req_if;
	logic          valid;
	logic          ready;
	cbc_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cbc_rsp_if;
	logic          valid;
	logic          ready;
	cbc_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/cartridge_bank_controller.sv */
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Decodes handheld-console cartridge bus accesses for MBC1/2/3/5 banking.
// ----------------------------------------------------------------------------
// Usage: each word on the req channel is one CPU bus access (read or write,
// 16-bit address, write byte). For every accepted word exactly one word leaves
// on the rsp channel: a target code, a physical ROM or external RAM byte
// offset, and a data byte (clock register contents, open bus value, or the
// value to be stored). Writes below 0x8000 update the bank registers.
// A word accepted into the input register is decoded there while the bank
// update runs; its result is registered in the result register once that
// register is empty or draining, and rsp.valid then rises.
// Throughput is one word per cycle while rsp.ready stays high; a new word
// is accepted while a result waits if the input register is empty or drains.
// When the receiver stalls, the result register holds, the input register
// fills, and req.ready drops only once both are occupied.
// The configuration port (cfg_write_enable, cfg_index, cfg_data) writes the
// controller kind, ROM size code and RAM bank count; write it only while idle.
// Reset (arst_n low) clears both stages, the configuration to zero and the
// bank state to its power-on values; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_defines.svh"

module cartridge_bank_controller (
	input  logic       clk,
	input  logic       arst_n,
	cbc_req_if.sink    req,
	cbc_rsp_if.source  rsp,
	input  logic       cfg_write_enable,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	import cbc_pkg::*;

	// Configuration registers.
	logic [2:0] kind_q;
	logic [3:0] rom_code_q;
	logic [4:0] ram_count_q;

	// Bank state.
	logic [8:0] rom_bank_q;
	logic [3:0] ram_bank_q;
	logic       ram_enable_q;
	logic [4:0] low_bits_q;
	logic [1:0] high_bits_q;
	logic       bank_mode_q;
	logic       clock_sel_q;
	logic [2:0] clock_idx_q;
	logic [7:0] clock_q [CLOCK_REGS];

	// Pipeline.
	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic advance;

	// Next-state values from the decode.
	rsp_t       rsp_d;
	logic [8:0] rom_bank_d;
	logic [3:0] ram_bank_d;
	logic       ram_enable_d;
	logic [4:0] low_bits_d;
	logic [1:0] high_bits_d;
	logic       bank_mode_d;
	logic       clock_sel_d;
	logic [2:0] clock_idx_d;
	logic       clock_we;

	logic [3:0] rom_code_sat;
	logic [8:0] rom_mask;

	// A waiting word moves on when the result register is empty or drains.
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Bank counts are powers of two, so the modulo becomes this mask.
	assign rom_code_sat = (rom_code_q > ROM_CODE_MAX) ? ROM_CODE_MAX : rom_code_q;
	assign rom_mask = 9'((10'd2 << rom_code_sat) - 10'd1);

	always_comb begin
		logic        wr;
		logic [15:0] a;
		logic [7:0]  v;
		logic [8:0]  bank;
		logic [4:0]  low_new;
		logic [1:0]  high_new;
		logic [6:0]  b7;
		logic [3:0]  b4;
		logic [7:0]  open_data;

		wr = req_s1.mode;
		a  = req_s1.address;
		v  = req_s1.write_value;
		open_data = wr ? 8'd0 : 8'hFF;
		bank = '0;
		low_new = '0;
		high_new = '0;
		b7 = '0;
		b4 = '0;

		rom_bank_d   = rom_bank_q;
		ram_bank_d   = ram_bank_q;
		ram_enable_d = ram_enable_q;
		low_bits_d   = low_bits_q;
		high_bits_d  = high_bits_q;
		bank_mode_d  = bank_mode_q;
		clock_sel_d  = clock_sel_q;
		clock_idx_d  = clock_idx_q;
		clock_we     = 1'b0;

		rsp_d.target      = TGT_NONE;
		rsp_d.mem_address = '0;
		rsp_d.data        = '0;

		if (!a[15]) begin
			if (wr) begin
				// Bank control writes.
				rsp_d.target = TGT_CTRL;
				case (kind_q)
					KIND_MBC1: begin
						case (a[14:13])
							2'd0: ram_enable_d = (v[3:0] == ENABLE_KEY);
							2'd1: begin
								low_new = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
								low_bits_d = low_new;
								rom_bank_d = bank_mode_q ? ({4'd0, low_new} & rom_mask)
									: ({2'd0, high_bits_q, low_new} & rom_mask);
							end
							2'd2: begin
								high_new = v[1:0];
								high_bits_d = high_new;
								if (!bank_mode_q) begin
									rom_bank_d = {2'd0, high_new, low_bits_q} & rom_mask;
								end else begin
									ram_bank_d = {2'd0, high_new};
								end
							end
							default: begin
								bank_mode_d = v[0];
								if (!v[0]) begin
									ram_bank_d = '0;
									rom_bank_d = {2'd0, high_bits_q, low_bits_q} & rom_mask;
								end else begin
									ram_bank_d = {2'd0, high_bits_q};
									rom_bank_d = {4'd0, low_bits_q} & rom_mask;
								end
							end
						endcase
					end
					KIND_MBC2: begin
						if (a[14]) begin
							rsp_d.target = TGT_OPEN;
						end else if (a[8]) begin
							b4 = (v[3:0] == 4'd0) ? 4'd1 : v[3:0];
							rom_bank_d = {5'd0, b4} & rom_mask;
						end else begin
							ram_enable_d = (v[3:0] == ENABLE_KEY);
						end
					end
					KIND_MBC3: begin
						case (a[14:13])
							2'd0: ram_enable_d = (v[3:0] == ENABLE_KEY);
							2'd1: begin
								b7 = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
								rom_bank_d = {2'd0, b7} & rom_mask;
							end
							2'd2: begin
								if (v <= 8'd3) begin
									clock_sel_d = 1'b0;
									ram_bank_d = v[3:0];
								end else if (v >= 8'd8 && v <= 8'd12) begin
									clock_sel_d = 1'b1;
									clock_idx_d = 3'(v - 8'd8);
								end
							end
							default: rsp_d.target = TGT_OPEN;
						endcase
					end
					KIND_MBC5: begin
						if (a[14:13] == 2'd0) begin
							ram_enable_d = (v[3:0] == ENABLE_KEY);
						end else if (a[14:12] == 3'd2) begin
							rom_bank_d = {rom_bank_q[8], v} & rom_mask;
						end else if (a[14:12] == 3'd3) begin
							rom_bank_d = {v[0], rom_bank_q[7:0]} & rom_mask;
						end else if (a[14:13] == 2'd2) begin
							ram_bank_d = v[3:0];
						end else begin
							rsp_d.target = TGT_OPEN;
						end
					end
					default: rsp_d.target = TGT_OPEN;
				endcase
				rsp_d.data = (rsp_d.target == TGT_CTRL) ? v : 8'd0;
			end else begin
				// ROM reads: the low window is bank 0 unless MBC1 mode 1 moves it.
				if (!a[14]) begin
					bank = (kind_q == KIND_MBC1 && bank_mode_q) ? {2'd0, high_bits_q, 5'd0}
						: 9'd0;
				end else begin
					bank = rom_bank_q;
				end
				if ((bank & ~rom_mask) == 9'd0) begin
					rsp_d.target = TGT_ROM;
					rsp_d.mem_address = {bank, a[13:0]};
				end else begin
					rsp_d.target = TGT_OPEN;
				end
				rsp_d.data = 8'hFF;
			end
		end else if (a[15:13] == 3'b101) begin
			// External RAM window.
			rsp_d.target = TGT_OPEN;
			rsp_d.data = open_data;
			if (ram_enable_q) begin
				if (kind_q == KIND_MBC3 && clock_sel_q) begin
					if (clock_idx_q < 3'(CLOCK_REGS)) begin
						rsp_d.target = TGT_CLK;
						clock_we = wr;
						rsp_d.data = wr ? v : clock_q[clock_idx_q];
					end
				end else if (kind_q == KIND_MBC2) begin
					rsp_d.target = TGT_NIB;
					rsp_d.mem_address = {14'd0, a[8:0]};
					rsp_d.data = wr ? {4'd0, v[3:0]} : 8'hFF;
				end else if ({1'b0, ram_bank_q} < ram_count_q) begin
					rsp_d.target = TGT_RAM;
					rsp_d.mem_address = {6'd0, ram_bank_q, a[12:0]};
					rsp_d.data = wr ? v : 8'hFF;
				end
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_NONE;
			rom_code_q  <= '0;
			ram_count_q <= '0;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				REG_KIND:      kind_q <= cfg_data[2:0];
				REG_ROM_SIZE:  rom_code_q <= cfg_data[3:0];
				REG_RAM_COUNT: ram_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bank state, updated as a word passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= 9'd1;
			ram_bank_q   <= '0;
			ram_enable_q <= 1'b0;
			low_bits_q   <= 5'd1;
			high_bits_q  <= '0;
			bank_mode_q  <= 1'b0;
			clock_sel_q  <= 1'b0;
			clock_idx_q  <= '0;
			for (int i = 0; i < CLOCK_REGS; i++) begin
				clock_q[i] <= CLOCK_RESET[i];
			end
		end else if (advance) begin
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
			ram_enable_q <= ram_enable_d;
			low_bits_q   <= low_bits_d;
			high_bits_q  <= high_bits_d;
			bank_mode_q  <= bank_mode_d;
			clock_sel_q  <= clock_sel_d;
			clock_idx_q  <= clock_idx_d;
			if (clock_we) begin
				clock_q[clock_idx_q] <= req_s1.write_value;
			end
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req.ready) begin
				req_valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	`CBC_ASSERT_NOW(a_rom_in_range, rsp_valid_q && rsp_q.target == TGT_ROM,
		(rsp_q.mem_address[22:14] & ~rom_mask) == 9'd0, "ROM offset beyond ROM size")
	`CBC_ASSERT_NOW(a_no_addr_off_memory,
		rsp_valid_q && rsp_q.target != TGT_ROM && rsp_q.target != TGT_RAM
		&& rsp_q.target != TGT_NIB, rsp_q.mem_address == 23'd0,
		"nonzero offset on a result that touches no memory")
	`CBC_ASSERT_NOW(a_nibble_mbc2, rsp_valid_q && rsp_q.target == TGT_NIB,
		kind_q == KIND_MBC2 && rsp_q.mem_address[22:9] == 14'd0,
		"nibble access outside MBC2 or beyond 512 entries")
	`CBC_ASSERT_NOW(a_clock_idx_range, 1'b1, clock_idx_q < 3'(CLOCK_REGS),
		"clock register index out of range")
	`CBC_ASSERT_NEXT(a_stage_holds, req_valid_s1 && !advance, req_valid_s1,
		"input stage dropped a word while stalled")

endmodule
